@@ sv/sxc_pkg.sv @@
// ----------------------------------------------------------------------------
// sxc_pkg: shared types and constants for the subset XOR counter
// Command codes, field widths, modulus and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package sxc_pkg;

  localparam int VALUE_W = 10;
  localparam int COUNT_W = 27;
  localparam int CMD_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(100000007);

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORBID = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  typedef struct packed {
    logic clr_we;     // clearing pass: write init value at idx, clear mark
    logic mark_set;   // forbid: set mark at the incoming value
    logic v_load;     // latch element value for an add
    logic add_rd;     // add: read idx and idx^v from the live bank
    logic bank_flip;  // add finished: swap live and shadow banks
    logic q_rd;       // query: read count and mark at idx
    logic acc_clr;    // query start: zero the accumulator
    logic out_load;   // move accumulator into the output register
  } dp_cmd_t;

endpackage

@@ sv/sxc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sxc_ctrl: sequencer for the subset XOR counter
// Steps the table index for clearing, add and query passes and owns the
// handshake state of both channels.
// ----------------------------------------------------------------------------
module sxc_ctrl #(
  parameter int VALUE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sxc_pkg::CMD_W-1:0]     in_cmd,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sxc_pkg::dp_cmd_t              cmd,
  output logic [VALUE_BITS-1:0]         idx
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_ADD       = 3'd2;
  localparam logic [2:0] S_ADD_DRAIN = 3'd3;
  localparam logic [2:0] S_QUERY     = 3'd4;
  localparam logic [2:0] S_QDRAIN    = 3'd5;
  localparam logic [2:0] S_QLOAD     = 3'd6;

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] idx_r, idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  idx_last;
  logic                  out_free;

  assign idx_last = &idx_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          unique case (in_cmd)
            sxc_pkg::CMD_START: begin
              state_nxt = S_CLEAR;
            end
            sxc_pkg::CMD_ADD: begin
              cmd.v_load = 1'b1;
              state_nxt  = S_ADD;
            end
            sxc_pkg::CMD_FORBID: begin
              cmd.mark_set = 1'b1;
            end
            sxc_pkg::CMD_QUERY: begin
              cmd.acc_clr = 1'b1;
              state_nxt   = S_QUERY;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add_rd = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_last) state_nxt = S_ADD_DRAIN;
      end
      S_ADD_DRAIN: begin
        // last write lands on this edge, then the shadow bank goes live
        cmd.bank_flip = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_QUERY: begin
        cmd.q_rd = 1'b1;
        idx_nxt  = idx_r + 1'b1;
        if (idx_last) state_nxt = S_QDRAIN;
      end
      S_QDRAIN: begin
        state_nxt = S_QLOAD;
      end
      S_QLOAD: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        idx_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign idx       = idx_r;

  // a clearing pass always starts at entry zero after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> (state_r == S_CLEAR && idx_r == '0))
    else $error("clearing pass did not start at entry zero after reset");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("output register loaded while holding a stalled result");

  // an add pass always drains and flips banks right after its last read
  a_add_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD && idx_last) |=> (state_r == S_ADD_DRAIN && idx_r == '0))
    else $error("add pass did not drain after the last entry");

  // index is zero whenever a new beat can be taken
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("index not at zero while idle");

endmodule

@@ sv/sxc_datapath.sv @@
// ----------------------------------------------------------------------------
// sxc_datapath: count tables, forbid marks and modular adders
// Two count banks ping-pong during an add; query accumulates the live bank
// over entries whose mark is clear.
// ----------------------------------------------------------------------------
module sxc_datapath #(
  parameter int VALUE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sxc_pkg::dp_cmd_t               cmd,
  input  logic [VALUE_BITS-1:0]          idx,
  input  logic [VALUE_BITS-1:0]          in_v,
  output logic [sxc_pkg::COUNT_W-1:0]    out_count
);

  localparam int DEPTH = 1 << VALUE_BITS;
  localparam int CW    = sxc_pkg::COUNT_W;

  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, sxc_pkg::COUNT_MOD}) s = s - {1'b0, sxc_pkg::COUNT_MOD};
    return s[CW-1:0];
  endfunction

  logic [CW-1:0] mem0 [DEPTH];
  logic [CW-1:0] mem1 [DEPTH];
  logic          mark_mem [DEPTH];

  logic                  bank_r, bank_nxt;
  logic                  add_wr_r, q_acc_r;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [VALUE_BITS-1:0] addr_r;
  logic [CW-1:0]         rd_a_r, rd_b_r;
  logic                  rd_mark_r;
  logic [CW-1:0]         acc_r, acc_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic [VALUE_BITS-1:0] addr_b;
  logic [VALUE_BITS-1:0] wa;
  logic [CW-1:0]         wd, sum, term;
  logic                  we0, we1;
  logic                  mark_we;
  logic [VALUE_BITS-1:0] mark_wa;

  assign addr_b = idx ^ v_r;
  assign sum    = mod_add(rd_a_r, rd_b_r);
  assign term   = rd_mark_r ? '0 : rd_a_r;

  // add writes the shadow bank, the clearing pass the live one
  assign wa  = cmd.clr_we ? idx : addr_r;
  assign wd  = cmd.clr_we ? ((idx == '0) ? CW'(1) : '0) : sum;
  assign we0 = (cmd.clr_we && !bank_r) || (add_wr_r && bank_r);
  assign we1 = (cmd.clr_we && bank_r) || (add_wr_r && !bank_r);

  assign mark_we = cmd.clr_we || cmd.mark_set;
  assign mark_wa = cmd.mark_set ? in_v : idx;

  assign bank_nxt      = bank_r ^ cmd.bank_flip;
  assign v_nxt         = cmd.v_load ? in_v : v_r;
  assign out_count_nxt = cmd.out_load ? acc_r : out_count_r;

  always_comb begin
    if (cmd.acc_clr) acc_nxt = '0;
    else if (q_acc_r) acc_nxt = mod_add(acc_r, term);
    else acc_nxt = acc_r;
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[wa] <= wd;
    if (we1) mem1[wa] <= wd;
    rd_a_r <= bank_r ? mem1[idx] : mem0[idx];
    rd_b_r <= bank_r ? mem1[addr_b] : mem0[addr_b];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= cmd.mark_set;
    rd_mark_r <= mark_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r   <= 1'b0;
      add_wr_r <= 1'b0;
      q_acc_r  <= 1'b0;
    end else begin
      bank_r   <= bank_nxt;
      add_wr_r <= cmd.add_rd;
      q_acc_r  <= cmd.q_rd;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    addr_r      <= idx;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_count = out_count_r;

endmodule

@@ sv/subset_xor_count_dp.sv @@
// ----------------------------------------------------------------------------
// subset_xor_count_dp: counts subsets of a multiset by XOR, mod 100000007
// Forbid: marks the value without leaving idle. Add: one table entry per cycle
// through the single write port of the shadow bank, then the banks swap.
// Query: one entry read and accumulated per cycle, then the result is loaded
// once the output register is free. Start: a clearing pass over the table.
// Reset (rst_n low, synchronous) runs the same clearing pass; in_stall stays
// high until it is done.
// ----------------------------------------------------------------------------
module subset_xor_count_dp #(
  parameter int VALUE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sxc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [sxc_pkg::VALUE_W-1:0]   in_value,
  // result channel, one beat per query
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sxc_pkg::COUNT_W-1:0]   out_count
);

  // value field is masked (or zero-extended) to the table index width
  localparam int EXT_W = (VALUE_BITS > sxc_pkg::VALUE_W) ? VALUE_BITS : sxc_pkg::VALUE_W;

  logic [EXT_W-1:0]      value_ext;
  logic [VALUE_BITS-1:0] value_m;
  logic [VALUE_BITS-1:0] idx;
  sxc_pkg::dp_cmd_t      cmd;

  assign value_ext = EXT_W'(in_value);
  assign value_m   = value_ext[VALUE_BITS-1:0];

  // sequencer: decodes beats, walks the table index, owns valid/stall
  sxc_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .idx       (idx)
  );

  // tables and arithmetic; the output register holds a result while the
  // next beat is taken
  sxc_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .in_v      (value_m),
    .out_count (out_count)
  );

endmodule

@@ test/tb_subset_xor_count_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subset_xor_count_dp: self-checking bench for the subset XOR counter
// Drives start/add/forbid/query beats with random gaps and result-side
// stalls. A local copy of the count table and forbid marks works out every
// query answer in order, and each result beat is checked against it.
// ----------------------------------------------------------------------------
module tb_subset_xor_count_dp;

  localparam int VALUE_W = sxc_pkg::VALUE_W;
  localparam int COUNT_W = sxc_pkg::COUNT_W;
  localparam int CMD_W   = sxc_pkg::CMD_W;

  localparam int VALUE_BITS = 10;
  localparam int TABLE_SIZE = 1 << VALUE_BITS;
  localparam logic [VALUE_W-1:0] VALUE_MASK = VALUE_W'(TABLE_SIZE - 1);
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  localparam int ITEM_TARGET  = 1170;
  // an add or query holds the block for a whole table pass; add the worst gap
  // and the worst result stall, then take it several times over
  localparam int QUIET_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 1100;
  localparam int MAX_PRINTS   = 40;
  localparam int OWED_DEPTH   = 8;
  localparam int ADDED_DEPTH  = 64;

  // every DUT input starts at a known value
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic [CMD_W-1:0]     in_cmd    = sxc_pkg::CMD_START;
  logic [VALUE_W-1:0]   in_value  = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic [COUNT_W-1:0]   out_count;

  // local picture of the block's state
  logic [COUNT_W-1:0]   tally      [TABLE_SIZE];
  logic [COUNT_W-1:0]   prev_tally [TABLE_SIZE];
  logic                 barred     [TABLE_SIZE];

  // answers of accepted queries still owed by the block, oldest first
  logic [COUNT_W-1:0]   owed_counts [OWED_DEPTH];
  int owed_wr = 0;
  int owed_rd = 0;

  // 0: no idling, 1: usual mix, 2: heavy idling
  int in_gap_mode    = 1;
  int out_stall_mode = 1;
  int stall_left     = 0;
  int quiet_cycles   = 0;

  int errors = 0;
  int items_sent = 0;
  int n_start = 0, n_add = 0, n_forbid = 0, n_query = 0;
  int results_seen = 0;
  int wrapped_answers = 0;   // long cases run, sized for counts to pass the modulus

  subset_xor_count_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_cmd   (in_cmd),
    .in_value (in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_count(out_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ERROR: %s", $time, msg);
  endtask

  // table back to its start picture: one empty subset at XOR zero
  function automatic void clear_case();
    for (int j = 0; j < TABLE_SIZE; j++) begin
      tally[j]  = '0;
      barred[j] = 1'b0;
    end
    tally[0] = COUNT_W'(1);
  endfunction

  // advance the local state by one accepted command beat
  function automatic void track_command(input logic [CMD_W-1:0] cmd,
                                        input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] v;
    logic [COUNT_W:0]   sum;
    v = value & VALUE_MASK;
    case (cmd)
      sxc_pkg::CMD_START: begin
        clear_case();
        n_start++;
      end
      sxc_pkg::CMD_ADD: begin
        // every entry sees the old table, so work from a snapshot
        for (int j = 0; j < TABLE_SIZE; j++) prev_tally[j] = tally[j];
        for (int j = 0; j < TABLE_SIZE; j++) begin
          sum = {1'b0, prev_tally[j]} +
                {1'b0, prev_tally[(j ^ int'(v)) & (TABLE_SIZE - 1)]};
          if (sum >= {1'b0, sxc_pkg::COUNT_MOD}) sum = sum - {1'b0, sxc_pkg::COUNT_MOD};
          tally[j] = sum[COUNT_W-1:0];
        end
        n_add++;
      end
      sxc_pkg::CMD_FORBID: begin
        barred[v] = 1'b1;
        n_forbid++;
      end
      default: begin
        sum = '0;
        for (int j = 0; j < TABLE_SIZE; j++) begin
          if (!barred[j]) begin
            sum = sum + {1'b0, tally[j]};
            if (sum >= {1'b0, sxc_pkg::COUNT_MOD}) sum = sum - {1'b0, sxc_pkg::COUNT_MOD};
          end
        end
        owed_counts[owed_wr % OWED_DEPTH] = sum[COUNT_W-1:0];
        owed_wr++;
        n_query++;
      end
    endcase
  endfunction

  // usual mix: mostly back to back, some short gaps, a few long ones; mode 0 never idles, mode 2 idles more
  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (mode == 2) r = r / 2 + 50;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // one command beat: hold it until accepted, then maybe idle
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    int gap;
    in_cmd   <= cmd;
    in_value <= value;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_command(cmd, value);
    items_sent++;
    gap = pick_gap(in_gap_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result side: check each beat, drive random stalls, and watch for a hang
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      results_seen++;
      if (owed_wr == owed_rd) begin
        flag_error($sformatf("result beat with no query pending, count=%0d", out_count));
      end else begin
        if (out_count !== owed_counts[owed_rd % OWED_DEPTH])
          flag_error($sformatf("count mismatch: got %0d, want %0d",
                               out_count, owed_counts[owed_rd % OWED_DEPTH]));
        owed_rd++;
      end
    end

    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_stall_mode != 0) begin
        int r;
        r = $urandom_range(0, 99);
        if (out_stall_mode == 2) r = r / 2;
        if (r < 25) stall_left = $urandom_range(1, 3);
        else if (r < 29) stall_left = $urandom_range(20, 80);
      end
    end

    if ((rst_n && in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t watchdog: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- tests ----

  // query before any start sees the reset table; forbids apply there too
  task automatic test_reset_state();
    send_beat(sxc_pkg::CMD_QUERY, ALL_ONES);
    send_beat(sxc_pkg::CMD_FORBID, '0);
    send_beat(sxc_pkg::CMD_QUERY, '0);
    send_beat(sxc_pkg::CMD_FORBID, '0);     // marking twice changes nothing
    send_beat(sxc_pkg::CMD_QUERY, '0);
    send_beat(sxc_pkg::CMD_START, ALL_ONES); // start ignores its value
  endtask

  // zero element doubles everything, extreme values, start clears marks
  task automatic test_add_extremes();
    send_beat(sxc_pkg::CMD_ADD, '0);
    send_beat(sxc_pkg::CMD_QUERY, '0);
    send_beat(sxc_pkg::CMD_ADD, ALL_ONES);
    send_beat(sxc_pkg::CMD_ADD, VALUE_W'(1));
    send_beat(sxc_pkg::CMD_QUERY, ALL_ONES);
    send_beat(sxc_pkg::CMD_FORBID, ALL_ONES);
    send_beat(sxc_pkg::CMD_FORBID, VALUE_W'(10'h3FE));
    send_beat(sxc_pkg::CMD_FORBID, '0);
    send_beat(sxc_pkg::CMD_QUERY, '0);
    send_beat(sxc_pkg::CMD_START, '0);
    send_beat(sxc_pkg::CMD_QUERY, '0);
  endtask

  // alternating bit patterns with no idling on either side
  task automatic test_back_to_back();
    in_gap_mode    = 0;
    out_stall_mode = 0;
    send_beat(sxc_pkg::CMD_START, VALUE_W'(10'h2AA));
    send_beat(sxc_pkg::CMD_ADD, VALUE_W'(10'h155));
    send_beat(sxc_pkg::CMD_ADD, VALUE_W'(10'h2AA));
    send_beat(sxc_pkg::CMD_FORBID, ALL_ONES);
    send_beat(sxc_pkg::CMD_QUERY, VALUE_W'(10'h155));
    send_beat(sxc_pkg::CMD_QUERY, VALUE_W'(10'h2AA));
    in_gap_mode    = 1;
    out_stall_mode = 1;
  endtask

  // random cases: mostly start, a run of adds/forbids/queries, final query;
  // some cases skip the start or are long enough for counts to wrap the modulus
  task automatic test_random_cases();
    logic [VALUE_W-1:0] added [ADDED_DEPTH];
    logic [VALUE_W-1:0] v;
    int n_added;
    int steps, add_pct, r;
    bit long_case;
    n_added = 0;
    while (items_sent < ITEM_TARGET) begin
      in_gap_mode    = $urandom_range(0, 5) == 0 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
      out_stall_mode = $urandom_range(0, 5) == 0 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
      long_case = ($urandom_range(0, 99) < 8);
      steps   = long_case ? $urandom_range(28, 40) : $urandom_range(1, 9);
      add_pct = long_case ? 85 : 45;

      if ($urandom_range(0, 9) != 0) begin
        send_beat(sxc_pkg::CMD_START, VALUE_W'($urandom));
        n_added = 0;
      end else begin
        // noise: carry on from whatever state is there, any command
        send_beat(CMD_W'($urandom), VALUE_W'($urandom));
      end

      for (int k = 0; k < steps; k++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) begin
          r = $urandom_range(0, 9);
          v = (r == 0) ? '0 : (r == 1) ? ALL_ONES : VALUE_W'($urandom);
          if (n_added < ADDED_DEPTH) begin
            added[n_added] = v;
            n_added++;
          end
          send_beat(sxc_pkg::CMD_ADD, v);
        end else if (r < add_pct + (100 - add_pct) * 2 / 3) begin
          // half the forbids hit an XOR that some subset really reaches
          v = VALUE_W'($urandom);
          if (n_added > 0 && $urandom_range(0, 1) == 1) begin
            v = '0;
            for (int i = 0; i < n_added; i++) if ($urandom_range(0, 1) == 1) v = v ^ added[i];
          end
          send_beat(sxc_pkg::CMD_FORBID, v);
        end else begin
          send_beat(sxc_pkg::CMD_QUERY, VALUE_W'($urandom));
        end
      end

      if (long_case) wrapped_answers++;
      send_beat(sxc_pkg::CMD_QUERY, VALUE_W'($urandom));
    end
  endtask

  // --------------------------------------------------------------- main ----
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;   // the block now runs its clearing pass with in_stall high

    clear_case();
    test_reset_state();
    test_add_extremes();
    test_back_to_back();
    test_random_cases();
    in_valid <= 1'b0;

    // every owed answer has to come out; the watchdog catches a hang
    while (owed_wr != owed_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (owed_wr != owed_rd)
      flag_error($sformatf("%0d query answers never arrived", owed_wr - owed_rd));

    $display("summary: %0d beats sent (%0d start, %0d add, %0d forbid, %0d query)",
             items_sent, n_start, n_add, n_forbid, n_query);
    $display("summary: %0d results checked, %0d long cases past the modulus, %0d errors",
             results_seen, wrapped_answers, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
